// ----- rtl/core/segment_lcd_frame_serializer_top_defines.svh -----
// ============================================================================
// segment_lcd_frame_serializer_top_defines.svh
// Assertion macros shared by the display serializer RTL.
// ============================================================================
`ifndef SEGMENT_LCD_FRAME_SERIALIZER_TOP_DEFINES_SVH
`define SEGMENT_LCD_FRAME_SERIALIZER_TOP_DEFINES_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define SLCD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define SLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/slcd_pkg.sv -----
// ============================================================================
// slcd_pkg
// Shared types and fixed protocol constants of the segment display serializer.
// ============================================================================
package slcd_pkg;

    // Request codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;
    localparam logic [1:0] ACT_ARM   = 2'd3;

    // Frame sequencing points of the bit counter
    localparam int unsigned CNT_W        = 10;
    localparam logic [CNT_W-1:0] CNT_DATA_LOW = 10'd3;
    localparam logic [CNT_W-1:0] CNT_LAST     = 10'd515;
    localparam logic [CNT_W-1:0] CNT_END      = 10'd516;

    // Result queue geometry
    localparam int unsigned RQ_DEPTH = 4;
    localparam int unsigned RQ_AW    = 2;
    localparam int unsigned RQ_LW    = 3;

    typedef struct packed {
        logic clock_out;
        logic strobe_out;
        logic data_out;
        logic frame_busy;
        logic last;
    } slcd_result_t;

endpackage

// ----- rtl/core/segment_lcd_frame_serializer_top.sv -----
// ============================================================================
// segment_lcd_frame_serializer_top
// Segment display pin sequencer driven from a stored one-bit frame.
// ============================================================================
// Usage:
//   The request channel (item_valid / item_stall) carries action, bit_pos
//   and bit_value. A tick advances the pin sequence; the other actions write
//   one frame bit, start a frame, or arm the start handshake.
//   The result channel (result_valid / result_stall) gives the pin levels,
//   frame_busy and last. A tick that makes a data pulse gives two results,
//   every other request gives one; last marks the final one of a request.
//   Throughput is one request per cycle while item_stall is low. Results
//   enter a four-entry queue in the cycle after acceptance. The frame
//   store is a single-port-write memory of FRAME_BITS bits; the bit for
//   the next counter value is read into a prefetch register, with the
//   write of the same cycle forwarded, so ticks never wait on the memory.
//   After reset a clearing pass zeroes the frame store, one bit a cycle,
//   over all FRAME_BITS addresses; item_stall is high during that pass.
//   When the receiver stalls, results collect in the queue and item_stall
//   rises once fewer than two free entries remain.
// ============================================================================
`include "segment_lcd_frame_serializer_top_defines.svh"

module segment_lcd_frame_serializer_top
    import slcd_pkg::*;
#(
    parameter int unsigned FRAME_BITS = 520
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [1:0] action,
    input  logic [9:0] bit_pos,
    input  logic       bit_value,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       clock_out,
    output logic       strobe_out,
    output logic       data_out,
    output logic       frame_busy,
    output logic       last
);

    localparam int unsigned AW = $clog2(FRAME_BITS);
    localparam logic [10:0] FRAME_LIMIT = 11'(FRAME_BITS);
    localparam logic [AW-1:0] CLR_LAST = AW'(FRAME_BITS - 1);

    // Control state
    logic              phase_reg,        phase_next;
    logic              active_reg,       active_next;
    logic              armed_reg,        armed_next;
    logic              second_reg,       second_next;
    logic [CNT_W-1:0]  cnt_reg,          cnt_next;
    logic              clock_reg,        clock_next;
    logic              strobe_reg,       strobe_next;
    logic              data_reg,         data_next;
    logic              clr_busy_reg;
    logic [AW-1:0]     clr_addr_reg;

    // Frame memory and prefetch
    logic              frame_mem [FRAME_BITS];
    logic              prefetch_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic              mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [CNT_W-1:0]  cnt_inc;

    logic              accept;
    logic              pulse;
    logic              write_hit;
    slcd_result_t      pulse_res;
    slcd_result_t      final_res;
    slcd_result_t      head;
    logic [RQ_LW-1:0]  fifo_level;
    logic              pop;

    assign accept    = item_valid & ~item_stall;
    assign item_stall = clr_busy_reg | (fifo_level > RQ_LW'(RQ_DEPTH - 2));
    assign write_hit = accept && (action == ACT_WRITE) && ({1'b0, bit_pos} < FRAME_LIMIT);
    assign cnt_inc   = cnt_reg + CNT_W'(1);

    // Work out the next pin and sequencing state for the request
    always_comb
    begin
        phase_next  = phase_reg;
        active_next = active_reg;
        armed_next  = armed_reg;
        second_next = second_reg;
        cnt_next    = cnt_reg;
        clock_next  = clock_reg;
        strobe_next = strobe_reg;
        data_next   = data_reg;
        pulse       = 1'b0;
        if (accept)
        begin
            case (action)
                ACT_WRITE:
                begin
                end
                ACT_START:
                begin
                    active_next = 1'b1;
                end
                ACT_ARM:
                begin
                    armed_next = 1'b1;
                end
                ACT_TICK:
                begin
                    phase_next = ~phase_reg;
                    if (!phase_reg)
                    begin
                        if (clock_reg)
                        begin
                            clock_next = 1'b0;
                            if (!second_reg)
                            begin
                                strobe_next = 1'b1;
                            end
                            else
                            begin
                                pulse     = 1'b1;
                                data_next = 1'b0;
                            end
                        end
                        else
                        begin
                            if (!armed_reg && !second_reg)
                            begin
                                strobe_next = 1'b1;
                            end
                            clock_next = 1'b1;
                            if (armed_reg)
                            begin
                                armed_next  = 1'b0;
                                second_next = 1'b1;
                                strobe_next = 1'b0;
                                data_next   = 1'b0;
                            end
                            else if (second_reg)
                            begin
                                second_next = 1'b0;
                                data_next   = 1'b1;
                                strobe_next = 1'b1;
                            end
                        end
                        if (active_reg)
                        begin
                            if (cnt_reg == CNT_DATA_LOW)
                            begin
                                data_next = 1'b0;
                            end
                            if (cnt_reg == CNT_LAST)
                            begin
                                data_next = 1'b1;
                            end
                        end
                    end
                    else if (active_reg)
                    begin
                        strobe_next = 1'b0;
                        if (cnt_reg > CNT_DATA_LOW)
                        begin
                            data_next = prefetch_reg;
                        end
                        if (cnt_inc == CNT_END)
                        begin
                            cnt_next    = '0;
                            active_next = 1'b0;
                            data_next   = 1'b1;
                        end
                        else
                        begin
                            cnt_next = cnt_inc;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= 1'b0;
            active_reg   <= 1'b0;
            armed_reg    <= 1'b0;
            second_reg   <= 1'b0;
            cnt_reg      <= '0;
            clock_reg    <= 1'b1;
            strobe_reg   <= 1'b1;
            data_reg     <= 1'b1;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            active_reg <= active_next;
            armed_reg  <= armed_next;
            second_reg <= second_next;
            cnt_reg    <= cnt_next;
            clock_reg  <= clock_next;
            strobe_reg <= strobe_next;
            data_reg   <= data_next;
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == CLR_LAST)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
        end
    end

    // Select the memory write: clearing pass first, then frame bit writes
    always_comb
    begin
        if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = 1'b0;
        end
        else
        begin
            mem_we    = write_hit;
            mem_waddr = bit_pos[AW-1:0];
            mem_wdata = bit_value;
        end
    end

    // Prefetch the bit for the next counter value
    assign mem_raddr = cnt_next[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_we && (mem_waddr == mem_raddr))
        begin
            prefetch_reg <= mem_wdata;
        end
        else
        begin
            prefetch_reg <= frame_mem[mem_raddr];
        end
    end

    // Build the results of the request
    always_comb
    begin
        pulse_res.clock_out  = 1'b0;
        pulse_res.strobe_out = strobe_reg;
        pulse_res.data_out   = 1'b1;
        pulse_res.frame_busy = active_reg;
        pulse_res.last       = 1'b0;
        final_res.clock_out  = clock_next;
        final_res.strobe_out = strobe_next;
        final_res.data_out   = data_next;
        final_res.frame_busy = active_next;
        final_res.last       = 1'b1;
    end

    assign pop = result_valid & ~result_stall;

    slcd_result_fifo u_result_fifo
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_first  (accept),
        .push_second (pulse),
        .first_data  (pulse ? pulse_res : final_res),
        .second_data (final_res),
        .pop         (pop),
        .head        (head),
        .level       (fifo_level)
    );

    assign result_valid = (fifo_level != '0);
    assign clock_out    = head.clock_out;
    assign strobe_out   = head.strobe_out;
    assign data_out     = head.data_out;
    assign frame_busy   = head.frame_busy;
    assign last         = head.last;

    // Checks
    `SLCD_ASSERT_SAME(a_room_for_pulse, accept, fifo_level <= RQ_LW'(RQ_DEPTH - 2), "request accepted without room for two results")
    `SLCD_ASSERT_SAME(a_cnt_in_frame, active_reg, cnt_reg < CNT_END, "bit counter past frame end")
    `SLCD_ASSERT_SAME(a_cnt_idle_zero, !active_reg, cnt_reg == '0, "bit counter nonzero while idle")

endmodule

// ----- rtl/core/slcd_result_fifo.sv -----
// ============================================================================
// slcd_result_fifo
// Small result queue taking up to two results per cycle and giving one.
// ============================================================================
module slcd_result_fifo
    import slcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_first,
    input  logic               push_second,
    input  slcd_result_t       first_data,
    input  slcd_result_t       second_data,
    input  logic               pop,
    output slcd_result_t       head,
    output logic [RQ_LW-1:0]   level
);

    slcd_result_t           entry_reg [RQ_DEPTH];
    logic [RQ_AW-1:0]       wr_ptr_reg;
    logic [RQ_AW-1:0]       wr_ptr_next;
    logic [RQ_AW-1:0]       rd_ptr_reg;
    logic [RQ_AW-1:0]       rd_ptr_next;
    logic [RQ_LW-1:0]       level_reg;
    logic [RQ_LW-1:0]       level_next;
    logic [RQ_AW-1:0]       second_ptr;

    assign second_ptr = wr_ptr_reg + RQ_AW'(1);

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RQ_AW'(push_first) + RQ_AW'(push_second);
        rd_ptr_next = rd_ptr_reg + RQ_AW'(pop);
        level_next  = level_reg + RQ_LW'(push_first) + RQ_LW'(push_second)
                      - RQ_LW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Store incoming results
    always_ff @(posedge clk)
    begin
        if (push_first)
        begin
            entry_reg[wr_ptr_reg] <= first_data;
        end
        if (push_second)
        begin
            entry_reg[second_ptr] <= second_data;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign level = level_reg;

endmodule
